FILE: rtl/m4asm_pkg.sv
// ----------------------------------------------------------------------------
// Matrix unit package
// Sizes, operation codes, sequencer states and saturation helpers for the
// streaming 4x4 fixed-point matrix add, subtract and multiply block.
// ----------------------------------------------------------------------------
package m4asm_pkg;

    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;
    localparam int CELLS     = DIM * DIM;
    localparam int IDX_W     = $clog2(CELLS);
    localparam int K_W       = $clog2(DIM);
    localparam int LCNT_W    = $clog2(2 * CELLS);
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + $clog2(DIM);
    localparam int TAG_W     = 2;
    localparam int MODE_W    = 2;

    localparam logic [MODE_W-1:0] MODE_MUL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUB = 2'd2;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    function automatic logic [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sh;
        logic [ACC_W-DATA_W:0]   hi;
        sh = acc >>> FRAC_BITS;
        hi = sh[ACC_W-1:DATA_W-1];
        if ((&hi) || !(|hi)) begin
            return sh[DATA_W-1:0];
        end else if (sh[ACC_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    function automatic logic [DATA_W-1:0] sat_lin(input logic [DATA_W:0] s);
        if (s[DATA_W] == s[DATA_W-1]) begin
            return s[DATA_W-1:0];
        end else if (s[DATA_W]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    function automatic logic [TAG_W-1:0] to_tag(input logic [K_W-1:0] v);
        logic [K_W+TAG_W-1:0] w;
        w = {{TAG_W{1'b0}}, v};
        return w[TAG_W-1:0];
    endfunction

endpackage

FILE: rtl/matrix4_add_sub_multiply_top.sv
// ----------------------------------------------------------------------------
// Streaming 4x4 matrix add, subtract and multiply
// Loads two Q16.16 matrices element by element and streams out the result.
// ----------------------------------------------------------------------------
// Input beats are taken on start while busy is low: 16 elements of A, then
// 16 of B, both row-major, one beat per cycle at most. Both matrices live in
// two RAMs with a registered read. The beat that carries the last
// element of B raises busy and samples the operation mode.
// Multiply reads one A and one B word per cycle and runs them through one
// 32x32 multiplier into an accumulator, which sums the products for one
// result; add and subtract read one word pair per result. Results follow
// at one per cycle when adding or subtracting; when multiplying, each
// result waits until its accumulation is complete.
// Each result beat is shown for one cycle with o_result_valid high, tagged
// with row, column and a last flag; the receiver cannot stall it.
// The mode register is written on its own channel, which is always ready.
// Reset clears the load count, the mode and the sequencer; the matrix RAMs
// are not cleared and every entry is rewritten before use.
// ----------------------------------------------------------------------------
module matrix4_add_sub_multiply_top (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic signed [m4asm_pkg::DATA_W-1:0]      i_element_value,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [m4asm_pkg::MODE_W-1:0]             i_cfg_data,
    output logic                                     o_result_valid,
    output logic signed [m4asm_pkg::DATA_W-1:0]      o_result_value,
    output logic [m4asm_pkg::TAG_W-1:0]              o_result_row,
    output logic [m4asm_pkg::TAG_W-1:0]              o_result_col,
    output logic                                     o_last_element
);

    localparam int IDX_W  = m4asm_pkg::IDX_W;
    localparam int K_W    = m4asm_pkg::K_W;
    localparam int LCNT_W = m4asm_pkg::LCNT_W;
    localparam int DATA_W = m4asm_pkg::DATA_W;
    localparam int PROD_W = m4asm_pkg::PROD_W;
    localparam int ACC_W  = m4asm_pkg::ACC_W;

    m4asm_pkg::t_state r_state, n_state;
    logic [LCNT_W-1:0]                r_load_cnt, n_load_cnt;
    logic [m4asm_pkg::MODE_W-1:0]     r_mode;
    logic [m4asm_pkg::MODE_W-1:0]     r_op, n_op;
    logic [K_W-1:0]                   r_row, n_row;
    logic [K_W-1:0]                   r_col, n_col;
    logic [K_W-1:0]                   r_k, n_k;

    logic              accept;
    logic              we_a, we_b;
    logic [IDX_W-1:0]  waddr_a, waddr_b;
    logic [IDX_W-1:0]  raddr_a, raddr_b;
    logic [DATA_W-1:0] rdata_a, rdata_b;
    logic              is_mul;
    logic              issue_valid, issue_first, issue_last, issue_cell_last;

    logic              r1_valid, r1_first, r1_last, r1_cell_last;
    logic [K_W-1:0]    r1_row, r1_col;
    logic              r2_valid, r2_first, r2_last, r2_cell_last;
    logic [K_W-1:0]    r2_row, r2_col;
    logic              r3_valid, r3_cell_last;
    logic [K_W-1:0]    r3_row, r3_col;

    logic signed [PROD_W-1:0] r_prod;
    logic [DATA_W-1:0]        r2_lin, r3_lin;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DATA_W-1:0] rd_a_s, rd_b_s;
    logic [DATA_W:0]          lin_sum;

    assign accept      = start && (r_state == m4asm_pkg::ST_LOAD);
    assign busy        = (r_state != m4asm_pkg::ST_LOAD);
    assign o_cfg_ready = 1'b1;
    assign is_mul      = (r_op == m4asm_pkg::MODE_MUL);

    assign we_a    = accept && (r_load_cnt < LCNT_W'(m4asm_pkg::CELLS));
    assign we_b    = accept && !(r_load_cnt < LCNT_W'(m4asm_pkg::CELLS));
    assign waddr_a = r_load_cnt[IDX_W-1:0];
    assign waddr_b = IDX_W'(r_load_cnt - LCNT_W'(m4asm_pkg::CELLS));

    always_comb begin
        if (is_mul) begin
            raddr_a = IDX_W'(r_row) * IDX_W'(m4asm_pkg::DIM) + IDX_W'(r_k);
            raddr_b = IDX_W'(r_k) * IDX_W'(m4asm_pkg::DIM) + IDX_W'(r_col);
        end else begin
            raddr_a = IDX_W'(r_row) * IDX_W'(m4asm_pkg::DIM) + IDX_W'(r_col);
            raddr_b = raddr_a;
        end
    end

    m4asm_ram #(.WIDTH(DATA_W), .DEPTH(m4asm_pkg::CELLS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr_a),
        .i_wdata (i_element_value),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    m4asm_ram #(.WIDTH(DATA_W), .DEPTH(m4asm_pkg::CELLS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr_b),
        .i_wdata (i_element_value),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    always_comb begin
        n_state         = r_state;
        n_load_cnt      = r_load_cnt;
        n_op            = r_op;
        n_row           = r_row;
        n_col           = r_col;
        n_k             = r_k;
        issue_valid     = 1'b0;
        issue_first     = !is_mul || (r_k == '0);
        issue_last      = !is_mul || (r_k == K_W'(m4asm_pkg::DIM - 1));
        issue_cell_last = (r_row == K_W'(m4asm_pkg::DIM - 1)) &&
                          (r_col == K_W'(m4asm_pkg::DIM - 1));
        case (r_state)
            m4asm_pkg::ST_LOAD: begin
                if (accept) begin
                    if (r_load_cnt == LCNT_W'(2 * m4asm_pkg::CELLS - 1)) begin
                        n_load_cnt = '0;
                        n_op       = r_mode;
                        n_row      = '0;
                        n_col      = '0;
                        n_k        = '0;
                        n_state    = m4asm_pkg::ST_ISSUE;
                    end else begin
                        n_load_cnt = r_load_cnt + 1'b1;
                    end
                end
            end
            m4asm_pkg::ST_ISSUE: begin
                issue_valid = 1'b1;
                if (!issue_last) begin
                    n_k = r_k + 1'b1;
                end else begin
                    n_k = '0;
                    if (r_col == K_W'(m4asm_pkg::DIM - 1)) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                        if (issue_cell_last) begin
                            n_state = m4asm_pkg::ST_DRAIN;
                        end
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            m4asm_pkg::ST_DRAIN: begin
                if (r3_valid && r3_cell_last) begin
                    n_state = m4asm_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = m4asm_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= m4asm_pkg::ST_LOAD;
            r_load_cnt     <= '0;
            r_mode         <= m4asm_pkg::MODE_MUL;
            r_op           <= m4asm_pkg::MODE_MUL;
            r_row          <= '0;
            r_col          <= '0;
            r_k            <= '0;
            r1_valid       <= 1'b0;
            r2_valid       <= 1'b0;
            r3_valid       <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_load_cnt     <= n_load_cnt;
            r_op           <= n_op;
            r_row          <= n_row;
            r_col          <= n_col;
            r_k            <= n_k;
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            r1_valid       <= issue_valid;
            r2_valid       <= r1_valid;
            r3_valid       <= r2_valid && r2_last;
            o_result_valid <= r3_valid;
        end
    end

    assign rd_a_s = rdata_a;
    assign rd_b_s = rdata_b;

    always_comb begin
        if (r_op == m4asm_pkg::MODE_SUB) begin
            lin_sum = {rdata_a[DATA_W-1], rdata_a} - {rdata_b[DATA_W-1], rdata_b};
        end else begin
            lin_sum = {rdata_a[DATA_W-1], rdata_a} + {rdata_b[DATA_W-1], rdata_b};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_first     <= issue_first;
        r1_last      <= issue_last;
        r1_cell_last <= issue_cell_last;
        r1_row       <= r_row;
        r1_col       <= r_col;

        r_prod       <= rd_a_s * rd_b_s;
        if ((r_op == m4asm_pkg::MODE_ADD) || (r_op == m4asm_pkg::MODE_SUB)) begin
            r2_lin <= m4asm_pkg::sat_lin(lin_sum);
        end else begin
            r2_lin <= '0;
        end
        r2_first     <= r1_first;
        r2_last      <= r1_last;
        r2_cell_last <= r1_cell_last;
        r2_row       <= r1_row;
        r2_col       <= r1_col;

        if (r2_valid) begin
            r_acc <= (r2_first ? '0 : r_acc) +
                     {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
        r3_lin       <= r2_lin;
        r3_cell_last <= r2_cell_last;
        r3_row       <= r2_row;
        r3_col       <= r2_col;

        if (is_mul) begin
            o_result_value <= m4asm_pkg::sat_acc(r_acc);
        end else begin
            o_result_value <= r3_lin;
        end
        o_result_row   <= m4asm_pkg::to_tag(r3_row);
        o_result_col   <= m4asm_pkg::to_tag(r3_col);
        o_last_element <= r3_cell_last;
    end

endmodule

FILE: rtl/m4asm_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module m4asm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
